// ===== rtl/core/itse_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Steering error package
// Shared types and constants for the inductive track steering error block.
// ----------------------------------------------------------------------------
package itse_pkg;

	localparam int ErrW   = 17;
	localparam int GainW  = 16;
	localparam int ErrMax = 51200;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_GAIN_LAT  = 3'd0,
		REG_GAIN_DIAG = 3'd1,
		REG_ISL_LAT   = 3'd2,
		REG_ISL_DIAG  = 3'd3,
		REG_SLOW_DIAG = 3'd4,
		REG_POS_SCALE = 3'd5,
		REG_NEG_SCALE = 3'd6
	} reg_idx_t;

	// track classes
	typedef enum logic [2:0] {
		CLS_LOST     = 3'd0,
		CLS_ISLAND   = 3'd1,
		CLS_CROSS    = 3'd2,
		CLS_RIGHT    = 3'd3,
		CLS_CURVE    = 3'd4,
		CLS_STRAIGHT = 3'd5
	} track_cls_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQRT,
		ST_MUL,
		ST_DIV,
		ST_SCALE,
		ST_OUT
	} seq_state_t;

endpackage

// ===== rtl/core/inductive_track_steering_error.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Inductive track steering error
// Classifies the track from eight coil readings and computes a saturated,
// sign-scaled steering error with a short error history.
// ----------------------------------------------------------------------------
// Sequence: ceil((ADC_BITS+17)/2) root steps (15 at ADC_BITS = 12), a multiply
// state, ADC_BITS+35 quotient steps (47) and a scale state, after which the result
// item is presented; a lost frame with no tuser mode bit set skips the divide.
// A new input item is not accepted until the result has been taken, since the
// root and quotient loops are not ready while busy.
// arst_n clears control, the gain registers to 1.0 and the history to zero.
// ----------------------------------------------------------------------------
module inductive_track_steering_error #(
	parameter int HISTORY_DEPTH = 5,
	parameter int ADC_BITS      = 12
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration write channel
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [2:0]              cfg_index,
	input  logic [15:0]             cfg_data,
	// tdata: horiz_left, horiz_right, middle_left, middle_right, diag_left,
	//        diag_right, vert_left, vert_right (ADC_BITS each, lowest first)
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [8*ADC_BITS-1:0]   s_tdata,
	// tuser: island_mode, slow_window, cross_mode
	input  logic [2:0]              s_tuser,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	// tdata: steer_error[16:0], track_class[19:17], island_seen[20],
	//        oldest_error[37:21], zero fill to 40 bits
	output logic [39:0]             m_tdata
);
	import itse_pkg::*;

	localparam int SW   = ADC_BITS + 1;        // middle sum width
	localparam int RW   = (SW + 17) / 2;       // root width
	localparam int RAD  = 2 * RW;              // radicand, even so bit pairs align
	localparam int DW   = SW + RW;             // denominator width
	localparam int WW   = ADC_BITS + 19;       // signed weighted sum width
	localparam int NW   = WW + 16;             // numerator magnitude width
	localparam int QW   = NW;
	localparam int EW   = 26;                  // capped error width
	localparam int PW   = EW + 17;             // scale product width
	localparam int RCW  = $clog2(RW + 1);
	localparam int QCW  = $clog2(QW + 1);
	// any error at or above this saturates under every nonzero scale
	localparam int ErrCap = 13107200;

	// configuration registers
	logic [15:0] g_lat_q, g_diag_q, i_lat_q, i_diag_q, s_diag_q, p_scl_q, n_scl_q;
	logic signed [ErrW-1:0] last_q;
	logic signed [ErrW-1:0] hist_q [HISTORY_DEPTH];

	seq_state_t state_q, state_d;

	logic [ADC_BITS-1:0] hl, hr, ml, mr, dl, dr, vl, vr;
	assign hl = s_tdata[0*ADC_BITS +: ADC_BITS];
	assign hr = s_tdata[1*ADC_BITS +: ADC_BITS];
	assign ml = s_tdata[2*ADC_BITS +: ADC_BITS];
	assign mr = s_tdata[3*ADC_BITS +: ADC_BITS];
	assign dl = s_tdata[4*ADC_BITS +: ADC_BITS];
	assign dr = s_tdata[5*ADC_BITS +: ADC_BITS];
	assign vl = s_tdata[6*ADC_BITS +: ADC_BITS];
	assign vr = s_tdata[7*ADC_BITS +: ADC_BITS];

	// classification on the incoming item
	logic [SW-1:0] sum_mid, sum_h;
	logic [ADC_BITS-1:0] ad_h, ad_d, ad_v;
	track_cls_t cls_in;
	assign sum_mid = {1'b0, ml} + {1'b0, mr};
	assign sum_h   = {1'b0, hl} + {1'b0, hr};
	assign ad_h = (hl > hr) ? hl - hr : hr - hl;
	assign ad_d = (dl > dr) ? dl - dr : dr - dl;
	assign ad_v = (vl > vr) ? vl - vr : vr - vl;

	always_comb begin
		if (32'(sum_mid) < 180) cls_in = CLS_LOST;
		else if (32'(sum_h) > 2000) cls_in = CLS_ISLAND;
		else if (32'(ad_d) > 300) begin
			if (32'(vl) > 100 && 32'(vr) > 100 && 32'(sum_mid) > 800) cls_in = CLS_CROSS;
			else if (32'(ad_v) > 60) cls_in = (32'(ad_h) < 90) ? CLS_RIGHT : CLS_CURVE;
			else cls_in = CLS_CURVE;
		end else if (32'(ad_h) <= 70 && 32'(ad_d) < 150) cls_in = CLS_STRAIGHT;
		else cls_in = CLS_CURVE;
	end

	// item registers
	track_cls_t cls_q;
	logic [SW-1:0] sum_q;
	logic signed [ADC_BITS:0] dh_q, dd_q;
	logic dbl_q, last_sel_q;
	logic [15:0] ga_q, gb_q;

	// root / divide registers
	logic [RAD-1:0] rem_q;
	logic [RW:0]    sq_rem_q;
	logic [RW-1:0]  root_q;
	logic [RCW-1:0] rcnt_q;
	logic [DW-1:0]  den_q;
	logic [NW-1:0]  num_q;
	logic           neg_q;
	logic [QW-1:0]  quo_q;
	logic [DW:0]    prem_q;
	logic [QCW-1:0] qcnt_q;
	logic signed [EW-1:0] err_q;
	logic signed [ErrW-1:0] res_q;

	logic accept;
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = (state_q == ST_OUT);

	// root step: restoring, two radicand bits a cycle
	logic [RW+2:0] rem_hi;
	logic [RW+2:0] trial;
	logic [RW+2:0] rem_new;
	assign rem_hi  = {sq_rem_q, rem_q[RAD-1 -: 2]};
	assign trial   = {1'b0, root_q, 2'b01};
	assign rem_new = rem_hi - trial;

	// signed weighted sum and its magnitude
	logic signed [WW-1:0] wsum;
	logic [WW-1:0] wmag;
	assign wsum = $signed({1'b0, ga_q}) * dh_q + $signed({1'b0, gb_q}) * dd_q;
	assign wmag = wsum[WW-1] ? $unsigned(-wsum) : $unsigned(wsum);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (accept) state_d = ST_SQRT;
			ST_SQRT:  if (rcnt_q == RCW'(RW - 1)) state_d = ST_MUL;
			ST_MUL:   state_d = last_sel_q ? ST_SCALE : ST_DIV;
			ST_DIV:   if (qcnt_q == QCW'(QW - 1)) state_d = ST_SCALE;
			ST_SCALE: state_d = ST_OUT;
			ST_OUT:   if (m_tready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			g_lat_q <= 16'd256; g_diag_q <= 16'd256; i_lat_q <= 16'd256;
			i_diag_q <= 16'd256; s_diag_q <= 16'd256; p_scl_q <= 16'd256;
			n_scl_q <= 16'd256;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_GAIN_LAT:  g_lat_q  <= cfg_data;
				REG_GAIN_DIAG: g_diag_q <= cfg_data;
				REG_ISL_LAT:   i_lat_q  <= cfg_data;
				REG_ISL_DIAG:  i_diag_q <= cfg_data;
				REG_SLOW_DIAG: s_diag_q <= cfg_data;
				REG_POS_SCALE: p_scl_q  <= cfg_data;
				REG_NEG_SCALE: n_scl_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// quotient step and the final signed, capped error
	logic [DW:0]   ptry;
	logic          q_bit;
	logic [QW-1:0] quo_nx;
	logic signed [EW-1:0] qsat, qdbl, qerr;
	assign ptry   = {prem_q[DW-1:0], num_q[NW-1]};
	assign q_bit  = ptry >= {1'b0, den_q};
	assign quo_nx = {quo_q[QW-2:0], q_bit};
	assign qsat   = (quo_nx > QW'(ErrCap)) ? EW'(ErrCap) : EW'(quo_nx);
	assign qdbl   = dbl_q ? qsat + qsat : qsat;
	assign qerr   = neg_q ? -qdbl : qdbl;

	// sign-dependent scale, truncate toward zero, saturate
	logic signed [PW-1:0] scl_prod;
	logic [PW-1:0] scl_mag;
	logic signed [ErrW-1:0] scl_res;
	assign scl_prod = err_q * $signed({1'b0, (err_q < 0) ? n_scl_q : p_scl_q});
	assign scl_mag = scl_prod[PW-1] ? $unsigned(-scl_prod) : $unsigned(scl_prod);

	always_comb begin
		if (scl_mag[PW-1:8] > (PW-8)'(ErrMax)) scl_res = ErrW'(ErrMax);
		else scl_res = ErrW'(scl_mag[PW-1:8]);
		if (scl_prod[PW-1]) scl_res = -scl_res;
	end

	// datapath sequencing
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (accept) begin
				cls_q  <= cls_in;
				sum_q  <= sum_mid;
				dh_q   <= $signed({1'b0, hl}) - $signed({1'b0, hr});
				dd_q   <= $signed({1'b0, dl}) - $signed({1'b0, dr});
				rem_q  <= RAD'({sum_mid, 16'd0});
				root_q <= '0;
				sq_rem_q <= '0;
				rcnt_q <= '0;
				last_sel_q <= 1'b0;
				dbl_q  <= 1'b0;
				if (s_tuser[0]) begin
					ga_q <= i_lat_q; gb_q <= i_diag_q;
				end else if (s_tuser[1]) begin
					ga_q <= '0; gb_q <= s_diag_q;
				end else if (s_tuser[2]) begin
					ga_q <= g_lat_q; gb_q <= '0; dbl_q <= 1'b1;
				end else if (cls_in == CLS_LOST) begin
					ga_q <= '0; gb_q <= '0; last_sel_q <= 1'b1;
				end else if (cls_in == CLS_CROSS) begin
					ga_q <= g_lat_q; gb_q <= '0;
				end else if (cls_in == CLS_RIGHT) begin
					ga_q <= '0; gb_q <= g_diag_q;
				end else begin
					ga_q <= g_lat_q; gb_q <= g_diag_q;
				end
			end
			ST_SQRT: begin
				rem_q <= rem_q << 2;
				rcnt_q <= rcnt_q + 1'b1;
				if (rem_hi >= trial) begin
					sq_rem_q <= rem_new[RW:0];
					root_q   <= {root_q[RW-2:0], 1'b1};
				end else begin
					sq_rem_q <= rem_hi[RW:0];
					root_q   <= {root_q[RW-2:0], 1'b0};
				end
			end
			ST_MUL: begin
				den_q  <= (sum_q == '0) ? DW'(256) : DW'(sum_q) * DW'(root_q);
				neg_q  <= wsum < 0;
				// times 51200
				num_q  <= (NW'(wmag) << 15) + (NW'(wmag) << 14) + (NW'(wmag) << 11);
				prem_q <= '0;
				qcnt_q <= '0;
				err_q  <= EW'(last_q) + EW'(last_q);
			end
			ST_DIV: begin
				num_q  <= num_q << 1;
				qcnt_q <= qcnt_q + 1'b1;
				quo_q  <= quo_nx;
				if (q_bit) prem_q <= ptry - {1'b0, den_q};
				else prem_q <= ptry;
				if (qcnt_q == QCW'(QW - 1)) err_q <= qerr;
			end
			default: ;
		endcase
	end

	// result and history update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
			for (int i = 0; i < HISTORY_DEPTH; i++) hist_q[i] <= '0;
		end else if (state_q == ST_SCALE) begin
			last_q <= scl_res;
			hist_q[0] <= scl_res;
			for (int i = 1; i < HISTORY_DEPTH; i++) hist_q[i] <= hist_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SCALE) res_q <= scl_res;
	end

	assign m_tdata = {2'b00, hist_q[HISTORY_DEPTH-1],
		(cls_q == CLS_ISLAND), cls_q, res_q};

endmodule
